/* rtl/cfsf_pkg.sv */
// Package for the common free slot finder.
// Holds the item types, list entry type, compare result type and defaults.
// Used by every module of the block but cfsf_ram; depends on nothing.
package cfsf_pkg;

  // Time stamp width of all interval bounds
  localparam int TIME_W = 32;

  // Default list capacity per party
  localparam int LIST_DEPTH_DEF = 64;

  // Reset value of the required window length
  localparam logic [TIME_W-1:0] MIN_LENGTH_RST = 32'd1;

  // Party codes carried in the kind field
  localparam logic PARTY_FIRST  = 1'b0;
  localparam logic PARTY_SECOND = 1'b1;

  // One loaded interval
  typedef struct packed {
    logic              kind;
    logic [TIME_W-1:0] slot_begin;
    logic [TIME_W-1:0] slot_finish;
    logic              final_req;
  } in_item_t;

  // One answer
  typedef struct packed {
    logic              found;
    logic [TIME_W-1:0] window_begin;
    logic [TIME_W-1:0] window_end;
    logic              overflow;
  } out_item_t;

  // One stored interval of a party list
  typedef struct packed {
    logic [TIME_W-1:0] t_begin;
    logic [TIME_W-1:0] t_finish;
  } entry_t;

  // Status from the shared compare unit to the sequencer
  typedef struct packed {
    logic              a_gt_b;
    logic              a_fin_lt_b;
    logic              fit;
    logic [TIME_W-1:0] lo;
  } cmp_res_t;

  // Sequencer states
  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_INS     = 7'b0000010,
    ST_SHIFT   = 7'b0000100,
    ST_PUT     = 7'b0001000,
    ST_MRG_RD  = 7'b0010000,
    ST_MRG_CMP = 7'b0100000,
    ST_EMIT    = 7'b1000000
  } state_t;

endpackage

/* rtl/cfsf_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// Used for the interval lists; depends on nothing.
module cfsf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/cfsf_cmp.sv */
// Shared compare unit of the free slot finder.
// Orders two intervals for sorted insertion and intersects them for the merge.
// Depends on cfsf_pkg.
module cfsf_cmp
  import cfsf_pkg::*;
(
  input  entry_t            a_ent,
  input  entry_t            b_ent,
  input  logic [TIME_W-1:0] min_len,
  output cmp_res_t          res
);

  logic [TIME_W-1:0] lo;
  logic [TIME_W-1:0] hi;
  logic [TIME_W-1:0] span;

  // Intersect: latest start, earliest finish
  assign lo   = (a_ent.t_begin > b_ent.t_begin) ? a_ent.t_begin : b_ent.t_begin;
  assign hi   = (a_ent.t_finish < b_ent.t_finish) ? a_ent.t_finish : b_ent.t_finish;
  assign span = hi - lo;

  // Order by start, then by finish; qualify the overlap against the length
  always_comb begin
    res.a_gt_b     = (a_ent.t_begin > b_ent.t_begin) ||
                     ((a_ent.t_begin == b_ent.t_begin) && (a_ent.t_finish > b_ent.t_finish));
    res.a_fin_lt_b = a_ent.t_finish < b_ent.t_finish;
    res.fit        = (hi >= lo) && (span >= min_len);
    res.lo         = lo;
  end

endmodule

/* rtl/common_free_slot_finder.sv */
// Common free slot finder: loads two sorted interval lists and finds the earliest
// common window of at least min_length. Each item takes one list entry per cycle
// through its party's list RAM: after the accepting edge in_stall stays high while
// the greater held entries move up one place each, and the interval is stored or
// dropped at once when the list is empty or full.
// An item with final_req then walks both lists with the shared compare unit: a read
// and a compare state per step over at most first_count + second_count - 1 steps,
// a further read state to see a list spent when no window fits, then the emit state
// to post the answer (waiting while the previous answer is still stalled); in_stall
// stays high for the whole of that work. The answer sits in an output register, so
// the next set may load while it waits. Depends on cfsf_pkg, cfsf_ram and cfsf_cmp.
module common_free_slot_finder
  import cfsf_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_item,
  input  logic              cfg_wr_en,
  input  logic [TIME_W-1:0] cfg_wr_data
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int EW = $bits(entry_t);

  state_t            state_r, state_nxt;
  in_item_t          item_r, item_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [CW-1:0]     first_cnt_r, first_cnt_nxt;
  logic [CW-1:0]     second_cnt_r, second_cnt_nxt;
  logic              dropped_r, dropped_nxt;
  logic [CW-1:0]     i_r, i_nxt;
  logic [CW-1:0]     j_r, j_nxt;
  logic              found_r, found_nxt;
  logic [TIME_W-1:0] wb_r, wb_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;
  logic [TIME_W-1:0] min_len_r;

  // List RAM controls
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  entry_t            wr_data;
  logic              ins_rd_en;
  logic [AW-1:0]     ins_rd_addr;
  logic              mrg_rd_en;
  logic              first_rd_en, second_rd_en;
  logic [AW-1:0]     first_rd_addr, second_rd_addr;
  logic [EW-1:0]     first_rd_data, second_rd_data;

  logic [CW-1:0]     sel_cnt;
  logic [CW-1:0]     sel_cnt_m1;
  logic [AW-1:0]     pos_m1;
  logic [AW-1:0]     pos_m2;
  entry_t            new_ent;
  entry_t            ins_ent;
  entry_t            cmp_a, cmp_b;
  cmp_res_t          cmp_res;
  logic              out_free;

  assign sel_cnt    = (item_r.kind == PARTY_SECOND) ? second_cnt_r : first_cnt_r;
  assign sel_cnt_m1 = sel_cnt - CW'(1);
  assign pos_m1     = pos_r - AW'(1);
  assign pos_m2     = pos_r - AW'(2);
  assign new_ent    = '{t_begin: item_r.slot_begin, t_finish: item_r.slot_finish};
  assign ins_ent    = (item_r.kind == PARTY_SECOND) ? entry_t'(second_rd_data)
                                                    : entry_t'(first_rd_data);
  assign out_free   = !out_valid_r || !out_stall;

  // Share the compare unit between insertion and merge
  assign cmp_a = (state_r == ST_MRG_CMP) ? entry_t'(first_rd_data) : ins_ent;
  assign cmp_b = (state_r == ST_MRG_CMP) ? entry_t'(second_rd_data) : new_ent;

  cfsf_cmp u_cmp (
    .a_ent   (cmp_a),
    .b_ent   (cmp_b),
    .min_len (min_len_r),
    .res     (cmp_res)
  );

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    pos_nxt        = pos_r;
    first_cnt_nxt  = first_cnt_r;
    second_cnt_nxt = second_cnt_r;
    dropped_nxt    = dropped_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    found_nxt      = found_r;
    wb_nxt         = wb_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_r;
    wr_en          = 1'b0;
    wr_addr        = pos_r;
    wr_data        = new_ent;
    ins_rd_en      = 1'b0;
    ins_rd_addr    = pos_m2;
    mrg_rd_en      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_item;
          i_nxt     = '0;
          j_nxt     = '0;
          found_nxt = 1'b0;
          wb_nxt    = '0;
          state_nxt = ST_INS;
        end
      end

      ST_INS: begin
        if (sel_cnt >= CW'(LIST_DEPTH)) begin
          // Drop the item for a full list
          dropped_nxt = 1'b1;
          state_nxt   = item_r.final_req ? ST_MRG_RD : ST_IDLE;
        end else if (sel_cnt == '0) begin
          wr_en   = 1'b1;
          wr_addr = '0;
          if (item_r.kind == PARTY_SECOND) begin
            second_cnt_nxt = second_cnt_r + CW'(1);
          end else begin
            first_cnt_nxt = first_cnt_r + CW'(1);
          end
          state_nxt = item_r.final_req ? ST_MRG_RD : ST_IDLE;
        end else begin
          // Fetch the last held entry
          ins_rd_en   = 1'b1;
          ins_rd_addr = sel_cnt_m1[AW-1:0];
          pos_nxt     = sel_cnt[AW-1:0];
          state_nxt   = ST_SHIFT;
        end
      end

      ST_SHIFT: begin
        if (cmp_res.a_gt_b) begin
          // Move the held entry up one place
          wr_en   = 1'b1;
          wr_addr = pos_r;
          wr_data = ins_ent;
          pos_nxt = pos_m1;
          if (pos_r == AW'(1)) begin
            state_nxt = ST_PUT;
          end else begin
            ins_rd_en   = 1'b1;
            ins_rd_addr = pos_m2;
          end
        end else begin
          wr_en   = 1'b1;
          wr_addr = pos_r;
          if (item_r.kind == PARTY_SECOND) begin
            second_cnt_nxt = second_cnt_r + CW'(1);
          end else begin
            first_cnt_nxt = first_cnt_r + CW'(1);
          end
          state_nxt = item_r.final_req ? ST_MRG_RD : ST_IDLE;
        end
      end

      ST_PUT: begin
        wr_en   = 1'b1;
        wr_addr = pos_r;
        if (item_r.kind == PARTY_SECOND) begin
          second_cnt_nxt = second_cnt_r + CW'(1);
        end else begin
          first_cnt_nxt = first_cnt_r + CW'(1);
        end
        state_nxt = item_r.final_req ? ST_MRG_RD : ST_IDLE;
      end

      ST_MRG_RD: begin
        if ((i_r < first_cnt_r) && (j_r < second_cnt_r)) begin
          mrg_rd_en = 1'b1;
          state_nxt = ST_MRG_CMP;
        end else begin
          state_nxt = ST_EMIT;
        end
      end

      ST_MRG_CMP: begin
        if (cmp_res.fit) begin
          found_nxt = 1'b1;
          wb_nxt    = cmp_res.lo;
          state_nxt = ST_EMIT;
        end else begin
          // Advance past the interval that ends first
          if (cmp_res.a_fin_lt_b) begin
            i_nxt = i_r + CW'(1);
          end else begin
            j_nxt = j_r + CW'(1);
          end
          state_nxt = ST_MRG_RD;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_nxt.found       = found_r;
          out_nxt.window_begin = wb_r;
          out_nxt.window_end  = found_r ? (wb_r + min_len_r) : '0;
          out_nxt.overflow    = dropped_r;
          first_cnt_nxt       = '0;
          second_cnt_nxt      = '0;
          dropped_nxt         = 1'b0;
          state_nxt           = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Route RAM reads: one party during insertion, both during the merge
  assign first_rd_en    = mrg_rd_en || (ins_rd_en && (item_r.kind == PARTY_FIRST));
  assign second_rd_en   = mrg_rd_en || (ins_rd_en && (item_r.kind == PARTY_SECOND));
  assign first_rd_addr  = mrg_rd_en ? i_r[AW-1:0] : ins_rd_addr;
  assign second_rd_addr = mrg_rd_en ? j_r[AW-1:0] : ins_rd_addr;

  cfsf_ram #(
    .WIDTH (EW),
    .DEPTH (LIST_DEPTH)
  ) u_first_ram (
    .clk     (clk),
    .wr_en   (wr_en && (item_r.kind == PARTY_FIRST)),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (first_rd_en),
    .rd_addr (first_rd_addr),
    .rd_data (first_rd_data)
  );

  cfsf_ram #(
    .WIDTH (EW),
    .DEPTH (LIST_DEPTH)
  ) u_second_ram (
    .clk     (clk),
    .wr_en   (wr_en && (item_r.kind == PARTY_SECOND)),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (second_rd_en),
    .rd_addr (second_rd_addr),
    .rd_data (second_rd_data)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      first_cnt_r  <= '0;
      second_cnt_r <= '0;
      dropped_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      min_len_r    <= MIN_LENGTH_RST;
    end else begin
      state_r      <= state_nxt;
      first_cnt_r  <= first_cnt_nxt;
      second_cnt_r <= second_cnt_nxt;
      dropped_r    <= dropped_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr_en) begin
        min_len_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    pos_r   <= pos_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    found_r <= found_nxt;
    wb_r    <= wb_nxt;
    out_r   <= out_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

/* rtl/cfsf_checker.sv */
// Port checker for the common free slot finder, bound to the top level.
// Watches both item channels over time; depends on cfsf_pkg.
module cfsf_checker
  import cfsf_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // Hold a stalled answer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("stalled answer changed or vanished");

  // Drop any answer on reset
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("answer valid after reset");

  // Busy in the cycle after an accepted item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted without taking a cycle");

  // Zero the window fields when no window was found
  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.found) |->
      ((out_item.window_begin == '0) && (out_item.window_end == '0)))
    else $error("window fields set without a window");

  // Window end never wraps below its start
  a_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.found) |-> (out_item.window_end >= out_item.window_begin))
    else $error("window end wrapped");

endmodule

bind common_free_slot_finder cfsf_checker u_cfsf_checker (.*);

/* sim/common_free_slot_finder_tb.sv */
// Testbench for common_free_slot_finder: drives sets of free intervals, predicts
// the earliest common window of each set and checks every answer in order.
// Depends on cfsf_pkg and the common_free_slot_finder RTL only.
`timescale 1ns / 100ps

module common_free_slot_finder_tb;
  import cfsf_pkg::*;

  localparam int SETTLE_CYCLES   = 300;
  localparam int PHASES_PER_MODE = 4;
  localparam int ITEMS_PER_PHASE = 42;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_stall;
  in_item_t          in_item     = '0;
  logic              out_valid;
  logic              out_stall   = 1'b0;
  out_item_t         out_item;
  logic              cfg_wr_en   = 1'b0;
  logic [TIME_W-1:0] cfg_wr_data = '0;

  int unsigned send_idle_pct = 0;
  int unsigned rcv_idle_pct  = 0;
  int unsigned hold_left     = 0;

  // Own copy of both party lists, the window length and the drop flag
  class window_scoreboard;
    bit [TIME_W-1:0] min_len;
    entry_t          lists[2][LIST_DEPTH_DEF];
    int unsigned     counts[2];
    bit              dropped;
    out_item_t       pending_windows[$];
    int unsigned     mismatches;

    function new();
      min_len    = MIN_LENGTH_RST;
      counts[0]  = 0;
      counts[1]  = 0;
      dropped    = 1'b0;
      mismatches = 0;
    endfunction

    task report_mismatch(string what, logic [TIME_W-1:0] got, logic [TIME_W-1:0] want);
      $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
      mismatches++;
    endtask

    // Two-pointer walk over both sorted lists; stop at the first pair that fits
    function out_item_t earliest_window();
      out_item_t       ans;
      int unsigned     i;
      int unsigned     j;
      entry_t          a;
      entry_t          b;
      bit [TIME_W-1:0] lo;
      bit [TIME_W-1:0] hi;
      ans = '0;
      i = 0;
      j = 0;
      while (!ans.found && i < counts[0] && j < counts[1]) begin
        a = lists[0][i];
        b = lists[1][j];
        lo = (a.t_begin > b.t_begin) ? a.t_begin : b.t_begin;
        hi = (a.t_finish < b.t_finish) ? a.t_finish : b.t_finish;
        if (hi >= lo && hi - lo >= min_len) begin
          ans.found        = 1'b1;
          ans.window_begin = lo;
          ans.window_end   = lo + min_len;
        end else if (a.t_finish < b.t_finish) begin
          i++;
        end else begin
          // equal ends advance the second party
          j++;
        end
      end
      ans.overflow = dropped;
      return ans;
    endfunction

    // Insert behind any equal pair already held; a final item closes the set
    function void note_interval(in_item_t it);
      int unsigned side;
      int unsigned n;
      entry_t      e;
      side = (it.kind == PARTY_SECOND) ? 1 : 0;
      n = counts[side];
      e.t_begin  = it.slot_begin;
      e.t_finish = it.slot_finish;
      if (n >= LIST_DEPTH_DEF) begin
        dropped = 1'b1;
      end else begin
        while (n > 0 && (lists[side][n-1].t_begin > e.t_begin ||
                         (lists[side][n-1].t_begin == e.t_begin &&
                          lists[side][n-1].t_finish > e.t_finish))) begin
          lists[side][n] = lists[side][n-1];
          n--;
        end
        lists[side][n] = e;
        counts[side]++;
      end
      if (it.final_req) begin
        pending_windows.push_back(earliest_window());
        counts[0] = 0;
        counts[1] = 0;
        dropped   = 1'b0;
      end
    endfunction

    task check_answer(out_item_t got);
      out_item_t want;
      if (pending_windows.size() == 0) begin
        report_mismatch("unexpected answer, window_begin", got.window_begin, '0);
      end else begin
        want = pending_windows.pop_front();
        if (got.found !== want.found)
          report_mismatch("found", TIME_W'(got.found), TIME_W'(want.found));
        if (got.window_begin !== want.window_begin)
          report_mismatch("window_begin", got.window_begin, want.window_begin);
        if (got.window_end !== want.window_end)
          report_mismatch("window_end", got.window_end, want.window_end);
        if (got.overflow !== want.overflow)
          report_mismatch("overflow", TIME_W'(got.overflow), TIME_W'(want.overflow));
      end
    endtask
  endclass

  window_scoreboard sb;

  common_free_slot_finder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Give up after a generous fixed time
  initial begin
    #10_000_000;
    $display("common_free_slot_finder test failed");
    $finish;
  end

  // Result side: check accepted answers, then pick the next stall
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        sb.check_answer(out_item);
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
    end
  end

  // Offer one interval, idling first at random, and hold it until taken
  task send_interval(logic side, logic [TIME_W-1:0] b, logic [TIME_W-1:0] f, logic fin);
    in_item_t it;
    it.kind        = side;
    it.slot_begin  = b;
    it.slot_finish = f;
    it.final_req   = fin;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_interval(it);
  endtask

  // Drop valid and wait until every answer is back and the block is quiet
  task settle();
    in_valid <= 1'b0;
    while (sb.pending_windows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_min_length(logic [TIME_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.min_len = v;
  endtask

  // One set: mostly intervals clustered near a random base, some fully random
  task send_random_set(int unsigned n_items);
    logic [TIME_W-1:0] base;
    logic [TIME_W-1:0] b;
    logic [TIME_W-1:0] f;
    logic [TIME_W-1:0] t;
    logic              one_sided;
    logic              fixed_side;
    logic              side;
    int unsigned       k;
    base       = $urandom();
    one_sided  = ($urandom_range(9) == 0);
    fixed_side = logic'($urandom_range(1));
    for (k = 0; k < n_items; k++) begin
      if ($urandom_range(4) == 0) begin
        b = $urandom();
        f = $urandom();
      end else begin
        b = base + $urandom_range(1000);
        f = b + $urandom_range(400);
      end
      if ($urandom_range(9) == 0) begin
        t = b;
        b = f;
        f = t;
      end
      side = one_sided ? fixed_side : logic'($urandom_range(1));
      send_interval(side, b, f, k == n_items - 1);
    end
  endtask

  initial begin
    int unsigned       mode;
    int unsigned       phase;
    int unsigned       sent;
    int unsigned       n;
    int unsigned       k;
    logic [TIME_W-1:0] len;
    logic              crowded;

    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 7;
    rcv_idle_pct  = 87;

    // Directed sets at the reset window length
    send_interval(PARTY_FIRST, 32'd10, 32'd20, 1'b0);
    send_interval(PARTY_SECOND, 32'd15, 32'd30, 1'b1);
    // out-of-order loading, equal begins, advance on the earlier end
    send_interval(PARTY_FIRST, 32'd100, 32'd200, 1'b0);
    send_interval(PARTY_FIRST, 32'd100, 32'd150, 1'b0);
    send_interval(PARTY_SECOND, 32'd50, 32'd60, 1'b0);
    send_interval(PARTY_SECOND, 32'd140, 32'd300, 1'b1);
    // one list empty
    send_interval(PARTY_FIRST, 32'd5, 32'd500, 1'b1);
    // inverted interval never qualifies
    send_interval(PARTY_FIRST, 32'd40, 32'd30, 1'b0);
    send_interval(PARTY_SECOND, 32'd0, 32'd100, 1'b1);
    // extremes of the time range, equal ends
    send_interval(PARTY_FIRST, 32'd0, 32'hFFFF_FFFF, 1'b0);
    send_interval(PARTY_SECOND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    settle();

    // Zero length: disjoint pair still fails, a single point fits
    write_min_length(32'd0);
    send_interval(PARTY_FIRST, 32'd0, 32'd5, 1'b0);
    send_interval(PARTY_SECOND, 32'd6, 32'd9, 1'b1);
    send_interval(PARTY_SECOND, 32'd7, 32'd9, 1'b0);
    send_interval(PARTY_FIRST, 32'd7, 32'd7, 1'b1);
    settle();

    // Longest length: only the full range fits, window end at the top
    write_min_length(32'hFFFF_FFFF);
    send_interval(PARTY_FIRST, 32'd0, 32'hFFFF_FFFF, 1'b0);
    send_interval(PARTY_SECOND, 32'd0, 32'hFFFF_FFFF, 1'b1);
    send_interval(PARTY_SECOND, 32'd1, 32'hFFFF_FFFF, 1'b0);
    send_interval(PARTY_FIRST, 32'd0, 32'hFFFF_FFFF, 1'b1);

    // Random sets under three idling profiles
    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 7;
          rcv_idle_pct  = 87;
        end
        1: begin
          send_idle_pct = 87;
          rcv_idle_pct  = 7;
        end
        default: begin
          send_idle_pct = 0;
          rcv_idle_pct  = 0;
        end
      endcase
      for (phase = 0; phase < PHASES_PER_MODE; phase++) begin
        settle();
        case (phase)
          0: len = 32'd0;
          1: len = $urandom_range(300);
          2: len = 32'hFFFF_FFFF;
          default: len = $urandom_range(1) ? MIN_LENGTH_RST : TIME_W'($urandom());
        endcase
        write_min_length(len);
        // hold the answer side off so the block fills and stalls its input
        if (mode == 2 && phase == 0) hold_left = 1500;
        // overfill one party's list; the final item may itself be dropped
        if (phase == 1) begin
          crowded = mode[0];
          n = LIST_DEPTH_DEF + 1 + $urandom_range(6);
          for (k = 0; k < n; k++) begin
            len = $urandom_range(5000);
            send_interval((k <= LIST_DEPTH_DEF) ? crowded : logic'($urandom_range(1)),
                          len, len + $urandom_range(3000), k == n - 1);
          end
        end
        sent = 0;
        while (sent < ITEMS_PER_PHASE) begin
          n = ($urandom_range(7) == 0) ? $urandom_range(20, 9) : $urandom_range(6, 1);
          send_random_set(n);
          sent += n;
        end
      end
    end

    settle();
    if (sb.mismatches == 0) begin
      $display("common_free_slot_finder test passed");
    end else begin
      $display("common_free_slot_finder test failed");
    end
    $finish;
  end

endmodule
